>>> hw/rtl/xdre_pkg.sv
// Shared types and constants of the XOR delta run-length encoder.
package xdre_pkg;

  localparam int unsigned ByteW  = 8;
  localparam logic [ByteW-1:0] MaxRun = 8'd255;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [ByteW-1:0] cur_byte;
    logic [ByteW-1:0] prev_byte;
    logic             frame_end;
  } xdre_in_t;

  typedef struct packed {
    logic [ByteW-1:0] run_length;
    logic [ByteW-1:0] run_byte;
    logic             last_pair;
  } xdre_out_t;

  typedef struct packed {
    logic      has_a;
    xdre_out_t pair_a;
    logic      has_b;
    xdre_out_t pair_b;
  } xdre_entry_t;

  typedef struct packed {
    logic        push;
    xdre_entry_t entry;
  } xdre_wr_t;

  typedef struct packed {
    logic        valid;
    xdre_entry_t entry;
  } xdre_head_t;

endpackage

>>> hw/rtl/xdre_front.sv
// Front end: XORs the input bytes, tracks the open run and classifies which pairs close.
module xdre_front
  import xdre_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  xdre_in_t in_word_i,
  output xdre_wr_t wr_o
);

  logic [ByteW-1:0] val_q, val_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic             open_q, open_d;

  logic [ByteW-1:0] xor_val;
  logic             chg;
  logic             cont;
  logic [ByteW-1:0] cnt_n;
  logic [ByteW-1:0] val_n;
  logic             close_b;

  always_comb begin
    xor_val = in_word_i.cur_byte ^ in_word_i.prev_byte;
    chg     = open_q && (xor_val != val_q);
    cont    = open_q && !chg;
    cnt_n   = cont ? cnt_q + 8'd1 : 8'd1;
    val_n   = cont ? val_q : xor_val;
    close_b = (cnt_n >= MaxRun) || in_word_i.frame_end;

    wr_o.entry.has_a             = chg;
    wr_o.entry.pair_a.run_length = cnt_q;
    wr_o.entry.pair_a.run_byte   = val_q;
    wr_o.entry.pair_a.last_pair  = 1'b0;
    wr_o.entry.has_b             = close_b;
    wr_o.entry.pair_b.run_length = cnt_n;
    wr_o.entry.pair_b.run_byte   = val_n;
    wr_o.entry.pair_b.last_pair  = in_word_i.frame_end;
    wr_o.push                    = accept_i && (chg || close_b);

    val_d  = val_q;
    cnt_d  = cnt_q;
    open_d = open_q;
    if (accept_i) begin
      val_d  = val_n;
      cnt_d  = close_b ? '0 : cnt_n;
      open_d = !close_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      cnt_q  <= '0;
      open_q <= 1'b0;
    end else begin
      val_q  <= val_d;
      cnt_q  <= cnt_d;
      open_q <= open_d;
    end
  end

  a_open_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (cnt_q != '0) && (cnt_q < MaxRun))
    else $error("open run has an impossible length");

  a_closed_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (cnt_q == '0))
    else $error("closed run keeps a non-zero length");

endmodule

>>> hw/rtl/xdre_fifo.sv
// Short queue of classified entries between the front and back ends.
module xdre_fifo
  import xdre_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  xdre_wr_t   wr_i,
  input  logic       rd_i,
  output logic       full_o,
  output xdre_head_t head_o
);

  xdre_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wr_i.push ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = rd_i ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (wr_i.push && !rd_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!wr_i.push && rd_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
    full_o       = (cnt_q == QCntW'(QDepth));
    head_o.valid = (cnt_q != '0);
    head_o.entry = mem_q[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wptr_q] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.push |-> (!full_o || rd_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> head_o.valid)
    else $error("queue read while empty");

endmodule

>>> hw/rtl/xdre_back.sv
// Back end: splits queued entries into single pairs and holds the output register.
module xdre_back
  import xdre_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  xdre_head_t head_i,
  output logic       rd_o,
  input  logic       pop,
  output logic       empty,
  output xdre_out_t  out_word_o
);

  logic      ovalid_q, ovalid_d;
  xdre_out_t out_q;
  logic      done_a_q, done_a_d;

  logic      load;
  logic      cur_is_a;
  logic      last_of_entry;
  xdre_out_t cur_pair;

  always_comb begin
    load          = head_i.valid && (!ovalid_q || pop);
    cur_is_a      = head_i.entry.has_a && !done_a_q;
    last_of_entry = cur_is_a ? !head_i.entry.has_b : 1'b1;
    cur_pair      = cur_is_a ? head_i.entry.pair_a : head_i.entry.pair_b;
    rd_o          = load && last_of_entry;

    done_a_d = done_a_q;
    if (load) begin
      done_a_d = cur_is_a && head_i.entry.has_b;
    end

    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (pop) begin
      ovalid_d = 1'b0;
    end

    empty      = !ovalid_q;
    out_word_o = out_q;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= cur_pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      done_a_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      done_a_q <= done_a_d;
    end
  end

  a_half_done_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_a_q |-> head_i.valid && head_i.entry.has_a && head_i.entry.has_b)
    else $error("split entry lost its second pair");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (out_q.run_length != '0))
    else $error("pair with zero run length");

endmodule

>>> hw/rtl/xor_delta_rle_encoder_top.sv
// Top level of the XOR delta run-length encoder.
// Each accepted word carries a current and a previous frame byte; their XOR is gathered
// into runs of up to 255 equal values, and each closed run leaves as one word holding
// the run length, the XOR byte and a last-pair flag. The input takes one word per cycle
// while the four-entry queue between front and back ends has room; the result side
// delivers one word per cycle from its output register while the queue holds entries
// and words are popped, so an input word that both breaks a run and ends the frame
// yields two result words. Each result is registered in the queue, then in the output register.
module xor_delta_rle_encoder_top
  import xdre_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  xdre_in_t  in_word_i,
  output logic      empty,
  input  logic      pop,
  output xdre_out_t out_word_o
);

  logic       accept;
  logic       rd;
  xdre_wr_t   wr;
  xdre_head_t head;

  assign accept = push && !full;

  xdre_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .wr_o      (wr)
  );

  xdre_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .rd_i   (rd),
    .full_o (full),
    .head_o (head)
  );

  xdre_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .rd_o       (rd),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o)
  );

endmodule
